// File: rtl/bbp_pkg.sv
package bbp_pkg;

  // Default field geometry (signed Q8.16 coordinates, Q1.16 parameters)
  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

  // Patch geometry
  localparam int GRID_DIM   = 4;
  localparam int GRID_SIZE  = GRID_DIM * GRID_DIM;
  localparam int NUM_AXES   = 3;
  localparam int IDX_BITS   = 2;

  // Lerp levels: three along the rows, three across them
  localparam int PIPE_DEPTH = 6;

  typedef struct packed {
    logic                wr_en;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } load_t;

endpackage

// File: rtl/bbp_grid.sv
module bbp_grid #(
  parameter int COORD_BITS = bbp_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bbp_pkg::load_t               load_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  // index: axis * GRID_SIZE + row * GRID_DIM + col
  output logic signed [COORD_BITS-1:0] grid_o [bbp_pkg::NUM_AXES * bbp_pkg::GRID_SIZE]
);

  localparam int GS = bbp_pkg::GRID_SIZE;

  logic signed [COORD_BITS-1:0] px_q [GS];
  logic signed [COORD_BITS-1:0] py_q [GS];
  logic signed [COORD_BITS-1:0] pz_q [GS];
  logic [3:0]                   wr_idx;

  assign wr_idx = {load_i.row, load_i.col};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GS; i++) begin
        px_q[i] <= '0;
        py_q[i] <= '0;
        pz_q[i] <= '0;
      end
    end else if (load_i.wr_en) begin
      px_q[wr_idx] <= point_x_i;
      py_q[wr_idx] <= point_y_i;
      pz_q[wr_idx] <= point_z_i;
    end
  end

  for (genvar i = 0; i < GS; i++) begin : g_out
    assign grid_o[0 * GS + i] = px_q[i];
    assign grid_o[1 * GS + i] = py_q[i];
    assign grid_o[2 * GS + i] = pz_q[i];
  end

endmodule

// File: rtl/bbp_lerp_stage.sv
module bbp_lerp_stage #(
  parameter int COORD_BITS = bbp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bbp_pkg::FRAC_BITS_DEF,
  parameter int LANES      = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] a_i [LANES],
  input  logic signed [COORD_BITS-1:0] b_i [LANES],
  input  logic [FRAC_BITS:0]           t_i,
  input  logic [FRAC_BITS:0]           u_i,
  input  logic [FRAC_BITS:0]           v_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [COORD_BITS-1:0] y_o [LANES],
  output logic [FRAC_BITS:0]           u_o,
  output logic [FRAC_BITS:0]           v_o
);

  localparam int PW = FRAC_BITS + 1;
  localparam int DW = COORD_BITS + 1;
  localparam int MW = PW + 1 + DW;

  // a + floor(t * (b - a) / 2^F); for t up to one the result lies between a and b
  function automatic logic signed [COORD_BITS-1:0] lerp(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b,
    input logic [PW-1:0]                t
  );
    logic signed [DW-1:0] diff;
    logic signed [MW-1:0] prod;
    logic signed [MW-1:0] sum;
    diff = DW'(b) - DW'(a);
    prod = $signed({1'b0, t}) * diff;
    sum  = MW'(a) + (prod >>> FRAC_BITS);
    return sum[COORD_BITS-1:0];
  endfunction

  logic                         valid_q;
  logic signed [COORD_BITS-1:0] y_q [LANES];
  logic [PW-1:0]                u_q, v_q;
  logic                         load_en;

  assign ready_o = !valid_q || ready_i;
  assign load_en = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      for (int i = 0; i < LANES; i++) begin
        y_q[i] <= lerp(a_i[i], b_i[i], t_i);
      end
      u_q <= u_i;
      v_q <= v_i;
    end
  end

  assign valid_o = valid_q;
  assign y_o     = y_q;
  assign u_o     = u_q;
  assign v_o     = v_q;

endmodule

// File: rtl/bicubic_bezier_patch_eval_top.sv
// Bicubic Bezier patch evaluator, de Casteljau in fixed point.
//
// Input channel (in_valid_i / in_ready_o): one transfer per item.
//   kind_i = 0 writes control point (row_i, col_i) from point_*_i; no result.
//   kind_i = 1 evaluates the patch at (u_coord_i, v_coord_i), Q1.16, where
//   values above one saturate to one.
// Output channel (out_valid_o / out_ready_i): one transfer per evaluate,
//   pos_*_o in signed Q8.16, tex_s_o = v, tex_t_o = one minus u.
// Pipeline: six register stages, one lerp level each (three along the rows at
//   v, three across them at u); out_valid_o and the result come straight
//   from the register of the last stage.
// Throughput: one item per clock while out_ready_i keeps the pipeline moving;
//   the stage with the widest lerp level (36 multipliers) sets the clock, not the rate.
// Loads take effect at their transfer edge; an evaluate samples the grid at
//   its own transfer, so later loads never disturb items in flight.
// Reset clears all control points to zero and empties the pipeline.
// Stall: each stage holds while its successor is full; bubbles collapse, so
//   up to six results queue behind a stalled receiver before in_ready_o drops.
module bicubic_bezier_patch_eval_top #(
  parameter int COORD_BITS = bbp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bbp_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [1:0]                   row_i,
  input  logic [1:0]                   col_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic [FRAC_BITS:0]           u_coord_i,
  input  logic [FRAC_BITS:0]           v_coord_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] pos_x_o,
  output logic signed [COORD_BITS-1:0] pos_y_o,
  output logic signed [COORD_BITS-1:0] pos_z_o,
  output logic [FRAC_BITS:0]           tex_s_o,
  output logic [FRAC_BITS:0]           tex_t_o
);

  localparam int PW = FRAC_BITS + 1;
  localparam int CW = COORD_BITS;
  localparam int NA = bbp_pkg::NUM_AXES;
  localparam int GS = bbp_pkg::GRID_SIZE;
  localparam int GD = bbp_pkg::GRID_DIM;
  localparam logic [PW-1:0] ParamOne = {1'b1, {FRAC_BITS{1'b0}}};

  // ---------------------------------------------------------------------------
  // Control point store
  // ---------------------------------------------------------------------------
  bbp_pkg::load_t      load;
  logic signed [CW-1:0] grid [NA * GS];
  logic                 s1_ready;

  assign in_ready_o = s1_ready;
  assign load.wr_en = in_valid_i && in_ready_o && !kind_i;
  assign load.row   = row_i;
  assign load.col   = col_i;

  bbp_grid #(.COORD_BITS(COORD_BITS)) u_grid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .grid_o    (grid)
  );

  // Parameters above one saturate before use and before the texture outputs
  logic [PW-1:0] u_sat, v_sat;
  assign u_sat = (u_coord_i > ParamOne) ? ParamOne : u_coord_i;
  assign v_sat = (v_coord_i > ParamOne) ? ParamOne : v_coord_i;

  // ---------------------------------------------------------------------------
  // Stage wiring. Lane indices are axis-major within each level.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] a1 [NA*12], b1 [NA*12], y1 [NA*12];
  logic signed [CW-1:0] a2 [NA*8],  b2 [NA*8],  y2 [NA*8];
  logic signed [CW-1:0] a3 [NA*4],  b3 [NA*4],  y3 [NA*4];
  logic signed [CW-1:0] a4 [NA*3],  b4 [NA*3],  y4 [NA*3];
  logic signed [CW-1:0] a5 [NA*2],  b5 [NA*2],  y5 [NA*2];
  logic signed [CW-1:0] a6 [NA],    b6 [NA],    y6 [NA];

  logic          v1, v2, v3, v4, v5;
  logic          r2, r3, r4, r5, r6;
  logic [PW-1:0] u1, u2, u3, u4, u5, u6;
  logic [PW-1:0] w1, w2, w3, w4, w5, w6;

  for (genvar c = 0; c < NA; c++) begin : g_axis
    for (genvar r = 0; r < GD; r++) begin : g_row
      // row level 1: three lerps over the four points of a row
      for (genvar j = 0; j < 3; j++) begin : g_l1
        assign a1[c*12 + r*3 + j] = grid[c*GS + r*GD + j];
        assign b1[c*12 + r*3 + j] = grid[c*GS + r*GD + j + 1];
      end
      for (genvar j = 0; j < 2; j++) begin : g_l2
        assign a2[c*8 + r*2 + j] = y1[c*12 + r*3 + j];
        assign b2[c*8 + r*2 + j] = y1[c*12 + r*3 + j + 1];
      end
      assign a3[c*4 + r] = y2[c*8 + r*2];
      assign b3[c*4 + r] = y2[c*8 + r*2 + 1];
    end
    // across the four row results at u
    for (genvar j = 0; j < 3; j++) begin : g_l4
      assign a4[c*3 + j] = y3[c*4 + j];
      assign b4[c*3 + j] = y3[c*4 + j + 1];
    end
    for (genvar j = 0; j < 2; j++) begin : g_l5
      assign a5[c*2 + j] = y4[c*3 + j];
      assign b5[c*2 + j] = y4[c*3 + j + 1];
    end
    assign a6[c] = y5[c*2];
    assign b6[c] = y5[c*2 + 1];
  end

  bbp_lerp_stage #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .LANES(NA*12)) u_s1 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (in_valid_i && kind_i), .ready_o (s1_ready),
    .a_i (a1), .b_i (b1), .t_i (v_sat), .u_i (u_sat), .v_i (v_sat),
    .valid_o (v1), .ready_i (r2), .y_o (y1), .u_o (u1), .v_o (w1)
  );

  bbp_lerp_stage #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .LANES(NA*8)) u_s2 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (v1), .ready_o (r2),
    .a_i (a2), .b_i (b2), .t_i (w1), .u_i (u1), .v_i (w1),
    .valid_o (v2), .ready_i (r3), .y_o (y2), .u_o (u2), .v_o (w2)
  );

  bbp_lerp_stage #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .LANES(NA*4)) u_s3 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (v2), .ready_o (r3),
    .a_i (a3), .b_i (b3), .t_i (w2), .u_i (u2), .v_i (w2),
    .valid_o (v3), .ready_i (r4), .y_o (y3), .u_o (u3), .v_o (w3)
  );

  bbp_lerp_stage #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .LANES(NA*3)) u_s4 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (v3), .ready_o (r4),
    .a_i (a4), .b_i (b4), .t_i (u3), .u_i (u3), .v_i (w3),
    .valid_o (v4), .ready_i (r5), .y_o (y4), .u_o (u4), .v_o (w4)
  );

  bbp_lerp_stage #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .LANES(NA*2)) u_s5 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (v4), .ready_o (r5),
    .a_i (a5), .b_i (b5), .t_i (u4), .u_i (u4), .v_i (w4),
    .valid_o (v5), .ready_i (r6), .y_o (y5), .u_o (u5), .v_o (w5)
  );

  // last stage doubles as the output register
  bbp_lerp_stage #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .LANES(NA)) u_s6 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (v5), .ready_o (r6),
    .a_i (a6), .b_i (b6), .t_i (u5), .u_i (u5), .v_i (w5),
    .valid_o (out_valid_o), .ready_i (out_ready_i), .y_o (y6), .u_o (u6), .v_o (w6)
  );

  assign pos_x_o = y6[0];
  assign pos_y_o = y6[1];
  assign pos_z_o = y6[2];
  assign tex_s_o = w6;
  assign tex_t_o = ParamOne - u6;

endmodule

// File: rtl/bbp_checker.sv
module bbp_checker #(
  parameter int COORD_BITS = bbp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bbp_pkg::FRAC_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         kind_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [COORD_BITS-1:0] pos_x_o,
  input logic signed [COORD_BITS-1:0] pos_y_o,
  input logic signed [COORD_BITS-1:0] pos_z_o,
  input logic [FRAC_BITS:0]           tex_s_o,
  input logic [FRAC_BITS:0]           tex_t_o
);

  localparam logic [FRAC_BITS:0] ParamOne = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int CntBits = $clog2(bbp_pkg::PIPE_DEPTH + 2);
  localparam logic [CntBits-1:0] MaxPending = CntBits'(bbp_pkg::PIPE_DEPTH);

  logic               eval_xfer, out_xfer;
  logic [CntBits-1:0] pending_q, pending_d;

  assign eval_xfer = in_valid_i && in_ready_o && kind_i;
  assign out_xfer  = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (eval_xfer && !out_xfer) begin
      pending_d = pending_q + 1'b1;
    end else if (out_xfer && !eval_xfer) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o)
      && $stable(pos_z_o) && $stable(tex_s_o) && $stable(tex_t_o))
    else $error("result changed while stalled");

  // no result without an evaluate in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without pending evaluate");

  // pipeline never holds more than one item per stage
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= MaxPending)
    else $error("more evaluates in flight than stages");

  // texture coordinates stay within [0, one]
  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tex_s_o <= ParamOne && tex_t_o <= ParamOne)
    else $error("texture coordinate above one");

endmodule

bind bicubic_bezier_patch_eval_top bbp_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_bbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pos_x_o     (pos_x_o),
  .pos_y_o     (pos_y_o),
  .pos_z_o     (pos_z_o),
  .tex_s_o     (tex_s_o),
  .tex_t_o     (tex_t_o)
);
